// ----- rtl/slfc_pkg.sv -----
package slfc_pkg;

    localparam int FRAME_BUFFER_DEPTH = 64;
    localparam int ADDR_W             = $clog2(FRAME_BUFFER_DEPTH);
    localparam int MAX_LEN            = FRAME_BUFFER_DEPTH - 5;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [7:0] SYNC_FIRST_RESET  = 8'h5a;
    localparam logic [7:0] SYNC_SECOND_RESET = 8'h3c;
    localparam logic [7:0] TAIL_VALUE_RESET  = 8'hDB;
    localparam logic [7:0] CMD_MIN           = 8'h01;
    localparam logic [7:0] CMD_MAX           = 8'h03;

    localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] REG_TAIL_VALUE  = 2'd2;

    typedef enum logic [2:0] {
        STATUS_OK          = 3'd0,
        STATUS_BAD_SUM     = 3'd1,
        STATUS_BAD_TAIL    = 3'd2,
        STATUS_UNKNOWN_CMD = 3'd3,
        STATUS_BAD_LENGTH  = 3'd4
    } status_t;

    typedef struct packed {
        status_t             status;
        logic [7:0]          cmd;
        logic [ADDR_W-1:0]   last_idx;
    } job_t;

    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
        logic [7:0]          data;
    } store_wr_t;

endpackage

// ----- rtl/slfc_front.sv -----
module slfc_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_write,
    input  logic [1:0]                     cfg_index,
    input  logic [7:0]                     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_rx_byte,
    input  logic                           queue_full,
    input  logic                           back_busy,
    output logic                           push,
    output slfc_pkg::job_t                 push_job,
    output slfc_pkg::store_wr_t            store_wr
);

    typedef enum logic [5:0] {
        PH_SYNC1 = 6'b000001,
        PH_SYNC2 = 6'b000010,
        PH_LEN   = 6'b000100,
        PH_BODY  = 6'b001000,
        PH_SUM   = 6'b010000,
        PH_TAIL  = 6'b100000
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic [7:0]                    sync_first_reg, sync_second_reg, tail_value_reg;
    logic [7:0]                    length_reg, length_next;
    logic [slfc_pkg::ADDR_W-1:0]   taken_reg, taken_next;
    logic [7:0]                    sum_reg, sum_next;
    logic [7:0]                    checksum_reg, checksum_next;
    logic [7:0]                    cmd_reg, cmd_next;
    logic                          accept;
    logic [8:0]                    taken_inc;
    slfc_pkg::status_t             tail_status;

    assign s_ready   = !queue_full && !((phase_reg == PH_BODY) && back_busy);
    assign accept    = s_valid && s_ready;
    assign taken_inc = 9'(taken_reg) + 9'd1;

    always_comb begin
        if (sum_reg != checksum_reg) begin
            tail_status = slfc_pkg::STATUS_BAD_SUM;
        end else if (s_rx_byte != tail_value_reg) begin
            tail_status = slfc_pkg::STATUS_BAD_TAIL;
        end else if (cmd_reg < slfc_pkg::CMD_MIN || cmd_reg > slfc_pkg::CMD_MAX) begin
            tail_status = slfc_pkg::STATUS_UNKNOWN_CMD;
        end else begin
            tail_status = slfc_pkg::STATUS_OK;
        end
    end

    always_comb begin
        phase_next        = phase_reg;
        length_next       = length_reg;
        taken_next        = taken_reg;
        sum_next          = sum_reg;
        checksum_next     = checksum_reg;
        cmd_next          = cmd_reg;
        push              = 1'b0;
        push_job.status   = slfc_pkg::STATUS_OK;
        push_job.cmd      = cmd_reg;
        push_job.last_idx = slfc_pkg::ADDR_W'(length_reg - 8'd1);
        store_wr.en       = 1'b0;
        store_wr.addr     = taken_reg;
        store_wr.data     = s_rx_byte;
        if (accept) begin
            case (phase_reg)
                PH_SYNC2: begin
                    if (s_rx_byte == sync_second_reg) begin
                        phase_next = PH_LEN;
                    end else if (s_rx_byte == sync_first_reg) begin
                        phase_next = PH_SYNC2;
                    end else begin
                        phase_next = PH_SYNC1;
                    end
                end
                PH_LEN: begin
                    if (s_rx_byte == 8'd0 || {1'b0, s_rx_byte} > 9'(slfc_pkg::MAX_LEN)) begin
                        push            = 1'b1;
                        push_job.status = slfc_pkg::STATUS_BAD_LENGTH;
                        push_job.cmd    = 8'd0;
                        phase_next      = PH_SYNC1;
                    end else begin
                        length_next = s_rx_byte;
                        taken_next  = '0;
                        sum_next    = 8'd0;
                        phase_next  = PH_BODY;
                    end
                end
                PH_BODY: begin
                    store_wr.en = 1'b1;
                    sum_next    = sum_reg + s_rx_byte;
                    taken_next  = slfc_pkg::ADDR_W'(taken_inc);
                    if (taken_reg == '0) begin
                        cmd_next = s_rx_byte;
                    end
                    if (taken_inc >= {1'b0, length_reg}) begin
                        phase_next = PH_SUM;
                    end
                end
                PH_SUM: begin
                    checksum_next = s_rx_byte;
                    phase_next    = PH_TAIL;
                end
                PH_TAIL: begin
                    push            = 1'b1;
                    push_job.status = tail_status;
                    phase_next      = PH_SYNC1;
                end
                default: begin
                    phase_next = (s_rx_byte == sync_first_reg) ? PH_SYNC2 : PH_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_SYNC1;
            sync_first_reg  <= slfc_pkg::SYNC_FIRST_RESET;
            sync_second_reg <= slfc_pkg::SYNC_SECOND_RESET;
            tail_value_reg  <= slfc_pkg::TAIL_VALUE_RESET;
            length_reg      <= 8'd0;
            taken_reg       <= '0;
            sum_reg         <= 8'd0;
            checksum_reg    <= 8'd0;
            cmd_reg         <= 8'd0;
        end else begin
            phase_reg    <= phase_next;
            length_reg   <= length_next;
            taken_reg    <= taken_next;
            sum_reg      <= sum_next;
            checksum_reg <= checksum_next;
            cmd_reg      <= cmd_next;
            if (cfg_write) begin
                case (cfg_index)
                    slfc_pkg::REG_SYNC_FIRST:  sync_first_reg  <= cfg_wdata;
                    slfc_pkg::REG_SYNC_SECOND: sync_second_reg <= cfg_wdata;
                    slfc_pkg::REG_TAIL_VALUE:  tail_value_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// ----- rtl/slfc_fifo.sv -----
module slfc_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  slfc_pkg::job_t   push_job,
    input  logic             pop,
    output slfc_pkg::job_t   head_job,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = $clog2(slfc_pkg::QUEUE_DEPTH);

    slfc_pkg::job_t     entry_reg [slfc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     count_reg;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (PTR_W+1)'(slfc_pkg::QUEUE_DEPTH));
    assign head_job = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/slfc_back.sv -----
module slfc_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  slfc_pkg::store_wr_t   store_wr,
    input  logic                  queue_empty,
    input  slfc_pkg::job_t        head_job,
    output logic                  pop,
    output logic                  back_busy,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_body_byte,
    output logic [5:0]            m_body_index,
    output logic [7:0]            m_command_code,
    output logic [2:0]            m_frame_status,
    output logic                  m_last_of_run
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_SEND = 3'b100
    } state_t;

    state_t                        state_reg;
    logic [7:0]                    store_mem [slfc_pkg::FRAME_BUFFER_DEPTH];
    logic [7:0]                    rd_data_reg;
    logic [slfc_pkg::ADDR_W-1:0]   idx_reg;
    slfc_pkg::job_t                job_reg;
    logic                          at_last;
    logic                          is_status;

    always_ff @(posedge aclk) begin
        if (store_wr.en) begin
            store_mem[store_wr.addr] <= store_wr.data;
        end
        rd_data_reg <= store_mem[idx_reg];
    end

    assign pop            = (state_reg == ST_IDLE) && !queue_empty;
    assign back_busy      = (state_reg != ST_IDLE) || !queue_empty;
    assign is_status      = (job_reg.status != slfc_pkg::STATUS_OK);
    assign at_last        = (idx_reg == job_reg.last_idx);
    assign m_valid        = (state_reg == ST_SEND);
    assign m_body_byte    = is_status ? 8'd0 : rd_data_reg;
    assign m_body_index   = is_status ? 6'd0 : 6'(idx_reg);
    assign m_command_code = job_reg.cmd;
    assign m_frame_status = job_reg.status;
    assign m_last_of_run  = is_status || at_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (!queue_empty) begin
                        job_reg <= head_job;
                        idx_reg <= '0;
                        if (head_job.status != slfc_pkg::STATUS_OK) begin
                            state_reg <= ST_SEND;
                        end else begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    state_reg <= ST_SEND;
                end
                ST_SEND: begin
                    if (m_ready) begin
                        if (is_status || at_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_READ;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/sync_length_sum_frame_checker.sv -----
// Frame checker for a byte-oriented serial link. Each transaction on the
// s_ channel carries one received byte. The block hunts for the two sync
// bytes, takes a length byte, stores the body while summing it modulo 256,
// then checks the checksum byte and the tail byte.
// A good frame with a known command gives one m_ transaction per body byte,
// command first, with m_last_of_run on the final one. Any bad frame gives a
// single status transaction. The cfg_ port sets the sync and tail bytes;
// the user must write it only while the block is idle, and the block
// itself does not enforce this. The front end takes one byte per cycle
// while s_ready is high. The back end takes a job from the queue in its
// idle state, then passes through a read state and a send state for each
// body byte, since the body store has a registered read port; a status
// result goes straight from idle to send. A two-entry frame queue
// separates the two halves.
// While the back end is still draining a frame, s_ready falls as soon as
// the next frame reaches its body, since both share the body store.
// A stall on m_ready holds the current result and, once the queue fills,
// stops the input too. Reset returns to the hunt with the default sync and
// tail bytes; the body store is not cleared.
module sync_length_sum_frame_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_body_byte,
    output logic [5:0]  m_body_index,
    output logic [7:0]  m_command_code,
    output logic [2:0]  m_frame_status,
    output logic        m_last_of_run
);

    logic                  push, pop, queue_full, queue_empty, back_busy;
    slfc_pkg::job_t        push_job, head_job;
    slfc_pkg::store_wr_t   store_wr;

    slfc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .queue_full (queue_full),
        .back_busy  (back_busy),
        .push       (push),
        .push_job   (push_job),
        .store_wr   (store_wr)
    );

    slfc_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    slfc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .store_wr       (store_wr),
        .queue_empty    (queue_empty),
        .head_job       (head_job),
        .pop            (pop),
        .back_busy      (back_busy),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_body_byte    (m_body_byte),
        .m_body_index   (m_body_index),
        .m_command_code (m_command_code),
        .m_frame_status (m_frame_status),
        .m_last_of_run  (m_last_of_run)
    );

endmodule

// ----- rtl/slfc_checker.sv -----
module slfc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_body_byte,
    input  logic [5:0]  m_body_index,
    input  logic [7:0]  m_command_code,
    input  logic [2:0]  m_frame_status,
    input  logic        m_last_of_run
);

    localparam logic [2:0] OK_CODE  = slfc_pkg::STATUS_OK;
    localparam logic [2:0] LEN_CODE = slfc_pkg::STATUS_BAD_LENGTH;

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("Result withdrawn before it was taken.");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_status != OK_CODE |-> m_last_of_run)
        else $error("Status result without the last marker.");

    a_status_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_status != OK_CODE |-> m_body_byte == 8'd0 && m_body_index == 6'd0)
        else $error("Status result carries body data.");

    a_bad_length_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_status == LEN_CODE |-> m_command_code == 8'd0)
        else $error("Bad length result carries a command.");

endmodule

bind sync_length_sum_frame_checker slfc_checker u_slfc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_body_byte    (m_body_byte),
    .m_body_index   (m_body_index),
    .m_command_code (m_command_code),
    .m_frame_status (m_frame_status),
    .m_last_of_run  (m_last_of_run)
);
